// ===== hdl/oss_pkg.sv =====
// ----------------------------------------------------------------------------
// oss_pkg: shared types, constants and elaboration helpers
// Action codes, sequencer states, the cell control bundle and the sizing
// functions for the registered OR-reduction tree.
// ----------------------------------------------------------------------------
`default_nettype none

package oss_pkg;

   localparam int CAPACITY_DEF = 1024;
   // fan-in of one reduction tree node
   localparam int TREE_RADIX   = 32;

   typedef enum logic [1:0] {
      ACT_INSERT,
      ACT_DELETE,
      ACT_SELECT,
      ACT_RANK
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_WAIT,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic       look;     // latch compare flags
      logic       ins_go;   // shift right from insertion point
      logic       del_go;   // shift left onto the deleted key
      logic       sel_ok;   // select position is in range
      action_type action;
   } cell_ctl_type;

   // node count at a tree level (level 0 is the leaves)
   function automatic int tree_width(int n, int lvl);
      int m;
      m = n;
      for (int j = 0; j < lvl; j++) m = (m + TREE_RADIX - 1) / TREE_RADIX;
      return m;
   endfunction

   function automatic int tree_levels(int n);
      int m;
      int l;
      m = n;
      l = 0;
      while (m > 1 || l == 0) begin
         m = (m + TREE_RADIX - 1) / TREE_RADIX;
         l++;
      end
      return l;
   endfunction

   // first flat node slot of registered level lvl
   function automatic int tree_offset(int n, int lvl);
      int s;
      s = 0;
      for (int j = 0; j < lvl; j++) s += tree_width(n, j + 1);
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/oss_cell.sv =====
// ----------------------------------------------------------------------------
// oss_cell: one slot of the sorted key row
// Compares its key against the operation value, flags its match for the
// reduction tree and shifts keys with its neighbors on insert and delete.
// ----------------------------------------------------------------------------
`default_nettype none

module oss_cell #(
   parameter int IW = 10,
   parameter int CW = 11
) (
   input  logic                      clock,
   input  oss_pkg::cell_ctl_type     ctl,
   input  logic [IW-1:0]             idx,
   input  logic [CW-1:0]             count,
   input  logic [IW-1:0]             kidx,
   input  logic signed [31:0]        value,
   input  logic                      left_below,
   input  logic                      left_below_q,
   input  logic signed [31:0]        left_key,
   input  logic signed [31:0]        right_key,
   output logic                      below,
   output logic                      below_q,
   output logic                      mark,
   output logic signed [31:0]        key_q
);

   logic signed [31:0] key_ff;
   logic signed [31:0] key_in;
   logic               below_ff;
   logic               occ;
   logic               eq;
   logic               first;
   logic               hit;

   always_comb begin
      occ   = CW'(idx) < count;
      below = occ && (key_ff < value);
      eq    = occ && (key_ff == value);
      // edge of the thermometer: first stored key not below value
      first = occ && !below && left_below;
      hit   = ctl.sel_ok && (kidx == idx);
      unique case (ctl.action) inside
         oss_pkg::ACT_INSERT, oss_pkg::ACT_DELETE: mark = eq;
         oss_pkg::ACT_SELECT:                      mark = hit;
         oss_pkg::ACT_RANK:                        mark = first;
      endcase
   end

   always_comb begin
      key_in = key_ff;
      if (ctl.ins_go && !below_ff) begin
         key_in = left_below_q ? value : left_key;
      end else if (ctl.del_go && !below_ff) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (ctl.look) begin
         below_ff <= below;
      end
   end

   assign below_q = below_ff;
   assign key_q   = key_ff;

endmodule

`default_nettype wire

// ===== hdl/oss_tree.sv =====
// ----------------------------------------------------------------------------
// oss_tree: registered OR-reduction over the cell match flags
// At most one cell is marked; its index and key come out after one
// register stage per tree level.
// ----------------------------------------------------------------------------
`default_nettype none

module oss_tree #(
   parameter int N  = 1024,
   parameter int IW = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [N-1:0]          mark,
   input  logic signed [31:0]    key [N],
   output logic                  done,
   output logic                  found,
   output logic [IW-1:0]         index,
   output logic signed [31:0]    key_out
);

   localparam int R      = oss_pkg::TREE_RADIX;
   localparam int LEVELS = oss_pkg::tree_levels(N);
   localparam int TOT    = oss_pkg::tree_offset(N, LEVELS);

   logic                  any_ff [TOT];
   logic [IW-1:0]         idx_ff [TOT];
   logic signed [31:0]    key_ff [TOT];
   logic [LEVELS-1:0]     vld_ff;

   for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
      localparam int NI = oss_pkg::tree_width(N, l);
      localparam int NO = oss_pkg::tree_width(N, l + 1);
      localparam int OI = (l == 0) ? 0 : oss_pkg::tree_offset(N, l - 1);
      localparam int OO = oss_pkg::tree_offset(N, l);

      for (genvar o = 0; o < NO; o++) begin : g_node
         localparam int CNT = (NI - o * R < R) ? NI - o * R : R;
         logic               any_c;
         logic [IW-1:0]      idx_c;
         logic signed [31:0] key_c;

         if (l == 0) begin : g_leaf
            always_comb begin
               any_c = 1'b0;
               idx_c = '0;
               key_c = '0;
               for (int c = 0; c < CNT; c++) begin
                  if (mark[o * R + c]) begin
                     any_c = 1'b1;
                     idx_c = idx_c | IW'(o * R + c);
                     key_c = key_c | key[o * R + c];
                  end
               end
            end
         end else begin : g_inner
            // lower level payloads are already zero when not marked
            always_comb begin
               any_c = 1'b0;
               idx_c = '0;
               key_c = '0;
               for (int c = 0; c < CNT; c++) begin
                  any_c = any_c | any_ff[OI + o * R + c];
                  idx_c = idx_c | idx_ff[OI + o * R + c];
                  key_c = key_c | key_ff[OI + o * R + c];
               end
            end
         end

         always_ff @(posedge clock) begin
            any_ff[OO + o] <= any_c;
            idx_ff[OO + o] <= idx_c;
            key_ff[OO + o] <= key_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= LEVELS'({vld_ff, start});
      end
   end

   assign done    = vld_ff[LEVELS-1];
   assign found   = any_ff[TOT-1];
   assign index   = idx_ff[TOT-1];
   assign key_out = key_ff[TOT-1];

endmodule

`default_nettype wire

// ===== hdl/order_statistic_set_unit.sv =====
// ----------------------------------------------------------------------------
// order_statistic_set_unit: sorted set of signed keys with rank and select
// A row of key cells kept in ascending order, with a registered reduction
// tree for lookup and neighbor shifts for insert and delete.
// ----------------------------------------------------------------------------
//   req channel (req_valid / req_stall) carries one operation per beat:
//   req_action 0 insert, 1 delete, 2 select k-th smallest, 3 rank.
//   Select and rank return one rsp beat (rsp_answer, rsp_invalid); insert
//   and delete return nothing.
//   Each beat runs a compare in every cell (look state), then the match flags go
//   through the reduction tree (L register levels, L = ceil(log32(CAPACITY)),
//   at least 1, 2 for 1024 entries), then the commit state shifts the cells.
//   A new request is taken only once the last one has committed (req_stall
//   is high outside the idle state).
//   The result sits in an output register, so the next request is taken
//   while a result waits. If rsp_stall holds and a second result is ready,
//   the commit waits and req_stall stays high until the first is taken.
//   Reset empties the set (count to zero) and drops any pending result;
//   key storage is not cleared, so the unit is ready the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module order_statistic_set_unit #(
   parameter int CAPACITY = oss_pkg::CAPACITY_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_answer,
   output logic                rsp_invalid
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   oss_pkg::state_type    state_ff;
   oss_pkg::state_type    state_in;
   oss_pkg::action_type   act_ff;
   logic signed [31:0]    value_ff;
   logic [IW-1:0]         kidx_ff;
   logic                  sel_ok_ff;
   logic                  sel_ok_in;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  found_ff;
   logic [IW-1:0]         tidx_ff;
   logic signed [31:0]    tkey_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic signed [31:0]    rsp_answer_ff;
   logic signed [31:0]    rsp_answer_in;
   logic                  rsp_invalid_ff;
   logic                  rsp_invalid_in;

   logic                  accept;
   logic                  is_query;
   logic                  commit_now;
   logic                  rsp_load;
   oss_pkg::cell_ctl_type ctl;

   logic [CAPACITY-1:0]   cell_below;
   logic [CAPACITY-1:0]   cell_below_q;
   logic [CAPACITY-1:0]   cell_mark;
   logic signed [31:0]    cell_key [CAPACITY];

   logic                  tree_done;
   logic                  tree_found;
   logic [IW-1:0]         tree_index;
   logic signed [31:0]    tree_key;

   // ---------------------------------------------------------------- cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic               lb;
      logic               lbq;
      logic signed [31:0] lk;
      logic signed [31:0] rk;

      if (i == 0) begin : g_head
         assign lb  = 1'b1;
         assign lbq = 1'b1;
         assign lk  = '0;
      end else begin : g_body
         assign lb  = cell_below[i-1];
         assign lbq = cell_below_q[i-1];
         assign lk  = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign rk = cell_key[i];
      end else begin : g_next
         assign rk = cell_key[i+1];
      end

      oss_cell #(
         .IW (IW),
         .CW (CW)
      ) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .idx          (IW'(i)),
         .count        (count_ff),
         .kidx         (kidx_ff),
         .value        (value_ff),
         .left_below   (lb),
         .left_below_q (lbq),
         .left_key     (lk),
         .right_key    (rk),
         .below        (cell_below[i]),
         .below_q      (cell_below_q[i]),
         .mark         (cell_mark[i]),
         .key_q        (cell_key[i])
      );
   end

   oss_tree #(
      .N  (CAPACITY),
      .IW (IW)
   ) u_tree (
      .clock   (clock),
      .reset   (reset),
      .start   (ctl.look),
      .mark    (cell_mark),
      .key     (cell_key),
      .done    (tree_done),
      .found   (tree_found),
      .index   (tree_index),
      .key_out (tree_key)
   );

   // ------------------------------------------------------------ sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         oss_pkg::ST_IDLE:   if (req_valid) state_in = oss_pkg::ST_LOOK;
         oss_pkg::ST_LOOK:   state_in = oss_pkg::ST_WAIT;
         oss_pkg::ST_WAIT:   if (tree_done) state_in = oss_pkg::ST_COMMIT;
         oss_pkg::ST_COMMIT: if (commit_now) state_in = oss_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      is_query   = (act_ff == oss_pkg::ACT_SELECT) || (act_ff == oss_pkg::ACT_RANK);
      req_stall  = state_ff != oss_pkg::ST_IDLE;
      accept     = req_valid && !req_stall;
      commit_now = (state_ff == oss_pkg::ST_COMMIT) &&
                   (!is_query || !rsp_valid_ff || !rsp_stall);
      rsp_load   = commit_now && is_query;

      ctl.look   = state_ff == oss_pkg::ST_LOOK;
      ctl.ins_go = commit_now && (act_ff == oss_pkg::ACT_INSERT) && !found_ff &&
                   (count_ff < CW'(CAPACITY));
      ctl.del_go = commit_now && (act_ff == oss_pkg::ACT_DELETE) && found_ff;
      ctl.sel_ok = sel_ok_ff;
      ctl.action = act_ff;
   end

   always_comb begin
      sel_ok_in = !req_value[31] && (req_value != '0) &&
                  ($unsigned(req_value) <= 32'(count_ff));

      count_in = count_ff;
      if (ctl.ins_go) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.del_go) begin
         count_in = count_ff - CW'(1);
      end

      if (act_ff == oss_pkg::ACT_SELECT) begin
         rsp_answer_in  = sel_ok_ff ? tkey_ff : '0;
         rsp_invalid_in = !sel_ok_ff;
      end else begin
         // no edge found means every stored key is below value
         rsp_answer_in  = found_ff ? 32'(tidx_ff) : 32'(count_ff);
         rsp_invalid_in = 1'b0;
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oss_pkg::ST_IDLE;
         act_ff       <= oss_pkg::ACT_INSERT;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            act_ff <= oss_pkg::action_type'(req_action);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff  <= req_value;
         kidx_ff   <= req_value[IW-1:0] - IW'(1);
         sel_ok_ff <= sel_ok_in;
      end
      if ((state_ff == oss_pkg::ST_WAIT) && tree_done) begin
         found_ff <= tree_found;
         tidx_ff  <= tree_index;
         tkey_ff  <= tree_key;
      end
      if (rsp_load) begin
         rsp_answer_ff  <= rsp_answer_in;
         rsp_invalid_ff <= rsp_invalid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_answer  = rsp_answer_ff;
   assign rsp_invalid = rsp_invalid_ff;

   // ----------------------------------------------------------- assertions
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("key count above capacity");

   a_count_at_commit: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> $past(state_ff == oss_pkg::ST_COMMIT))
      else $error("key count changed outside commit");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == oss_pkg::ST_COMMIT))
      else $error("result raised outside commit");

   a_select_hits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == oss_pkg::ST_COMMIT && act_ff == oss_pkg::ACT_SELECT && sel_ok_ff)
      |-> found_ff)
      else $error("in-range select found no cell");

endmodule

`default_nettype wire
